FILE: design/q24alu_pkg.sv
// shared types and constants for the q24.8 fixed-point alu
// no dependencies; imported by every module of the block
package q24alu_pkg;

    localparam int QA_FRAC_BITS = 8;
    localparam int QA_DATA_W    = 32;

    typedef enum logic [3:0] {
        FN_ADD = 4'd0,
        FN_SUB = 4'd1,
        FN_MUL = 4'd2,
        FN_DIV = 4'd3,
        FN_INC = 4'd4,
        FN_DEC = 4'd5,
        FN_GT  = 4'd6,
        FN_LT  = 4'd7,
        FN_GE  = 4'd8,
        FN_LE  = 4'd9,
        FN_EQ  = 4'd10,
        FN_NE  = 4'd11,
        FN_MIN = 4'd12,
        FN_MAX = 4'd13,
        FN_I2F = 4'd14,
        FN_F2I = 4'd15
    } func_t;

    // per-stage control that rides along the cell chain
    typedef struct packed {
        logic valid;
        logic is_mul;
        logic is_div;
        logic neg;
        logic cmp;
        logic dz;
    } ctrl_t;

endpackage

FILE: design/q24alu_front.sv
// front stage: decodes the opcode, does every operation but the divide, including the
// multiply, and sets up the divider operands; depends on q24alu_pkg
module q24alu_front
    import q24alu_pkg::*;
#(
    parameter int FRAC_BITS = QA_FRAC_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  func_t                 in_func,
    input  logic [31:0]           in_a,
    input  logic [31:0]           in_b,
    output ctrl_t                 out_ctrl,
    output logic [31:0]           out_res,
    output logic [32+FRAC_BITS-1:0] out_nq,
    output logic [31:0]           out_d
);

    localparam int NW = 32 + FRAC_BITS;

    ctrl_t              ctrl_reg, ctrl_next;
    logic [31:0]        res_reg, res_next;
    logic signed [63:0] prod_reg, prod_next;
    logic [NW-1:0]      nq_reg, nq_next;
    logic [31:0]        d_reg, d_next;
    logic signed [31:0] sa, sb;
    logic               lt, eq;

    always_comb begin
        sa = $signed(in_a);
        sb = $signed(in_b);
        lt = sa < sb;
        eq = in_a == in_b;
        prod_next = sa * sb;
        nq_next = {(in_a[31] ? 32'(32'd0 - in_a) : in_a), {FRAC_BITS{1'b0}}};
        d_next  = in_b[31] ? 32'(32'd0 - in_b) : in_b;
        ctrl_next        = '0;
        ctrl_next.valid  = in_valid;
        ctrl_next.is_mul = in_func == FN_MUL;
        ctrl_next.is_div = in_func == FN_DIV;
        ctrl_next.neg    = in_a[31] ^ in_b[31];
        ctrl_next.dz     = (in_func == FN_DIV) && (in_b == 32'd0);
        res_next = '0;
        unique case (in_func)
            FN_ADD: res_next = in_a + in_b;
            FN_SUB: res_next = in_a - in_b;
            FN_INC: res_next = in_a + 32'd1;
            FN_DEC: res_next = in_a - 32'd1;
            FN_GT:  ctrl_next.cmp = !lt && !eq;
            FN_LT:  ctrl_next.cmp = lt;
            FN_GE:  ctrl_next.cmp = !lt;
            FN_LE:  ctrl_next.cmp = lt || eq;
            FN_EQ:  ctrl_next.cmp = eq;
            FN_NE:  ctrl_next.cmp = !eq;
            FN_MIN: res_next = (lt || eq) ? in_a : in_b;
            FN_MAX: res_next = !lt ? in_a : in_b;
            FN_I2F: res_next = in_a << FRAC_BITS;
            FN_F2I: res_next = 32'(sa >>> FRAC_BITS);
            default: res_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (en) begin
            ctrl_reg <= ctrl_next;
        end
        if (en) begin
            res_reg  <= res_next;
            prod_reg <= prod_next;
            nq_reg   <= nq_next;
            d_reg    <= d_next;
        end
    end

    // the multiply result is the product shifted by the fraction width
    assign out_ctrl = ctrl_reg;
    assign out_res  = ctrl_reg.is_mul ? prod_reg[FRAC_BITS+31:FRAC_BITS] : res_reg;
    assign out_nq   = nq_reg;
    assign out_d    = d_reg;

endmodule

FILE: design/q24alu_div_cell.sv
// one cell of the divider chain: resolves one quotient bit per item by
// restoring compare-subtract and passes the rest along; depends on q24alu_pkg
module q24alu_div_cell
    import q24alu_pkg::*;
#(
    parameter int NW = 32 + QA_FRAC_BITS
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  ctrl_t         in_ctrl,
    input  logic [31:0]   in_res,
    input  logic [NW-1:0] in_nq,
    input  logic [31:0]   in_rem,
    input  logic [31:0]   in_d,
    output ctrl_t         out_ctrl,
    output logic [31:0]   out_res,
    output logic [NW-1:0] out_nq,
    output logic [31:0]   out_rem,
    output logic [31:0]   out_d
);

    ctrl_t         ctrl_reg;
    logic [31:0]   res_reg;
    logic [NW-1:0] nq_reg, nq_next;
    logic [31:0]   rem_reg, rem_next;
    logic [31:0]   d_reg;
    logic [32:0]   trial, diff;
    logic          take;

    // dividend bits leave at the top, quotient bits enter at the bottom
    always_comb begin
        trial    = {in_rem, in_nq[NW-1]};
        diff     = trial - {1'b0, in_d};
        take     = trial >= {1'b0, in_d};
        rem_next = take ? diff[31:0] : trial[31:0];
        nq_next  = {in_nq[NW-2:0], take};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (en) begin
            ctrl_reg <= in_ctrl;
        end
        if (en) begin
            res_reg <= in_res;
            nq_reg  <= nq_next;
            rem_reg <= rem_next;
            d_reg   <= in_d;
        end
    end

    assign out_ctrl = ctrl_reg;
    assign out_res  = res_reg;
    assign out_nq   = nq_reg;
    assign out_rem  = rem_reg;
    assign out_d    = d_reg;

endmodule

FILE: design/q24_8_fixed_point_alu.sv
// stages from accepted item to result: one front stage, one divider cell per dividend
// bit (32 + FRAC_BITS) and one output register.
// throughput: one item per cycle; all stages advance together whenever the output
// register is empty or being taken, so a stalled result holds the whole chain.
// reset: synchronous active-low aresetn clears every stage valid and the output valid.
module q24_8_fixed_point_alu
    import q24alu_pkg::*;
#(
    parameter int FRAC_BITS = QA_FRAC_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // func[3:0], operand_a[35:4], operand_b[67:36], zero[71:68]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // result[31:0], compare_true[32], divide_by_zero[33], zero[39:34]
);

    localparam int NW = 32 + FRAC_BITS;

    logic        en;
    ctrl_t       st_ctrl [NW+1];
    logic [31:0] st_res  [NW+1];
    logic [NW-1:0] st_nq [NW+1];
    logic [31:0] st_rem  [NW+1];
    logic [31:0] st_d    [NW+1];

    logic        m_valid_reg;
    logic [31:0] m_res_reg, m_res_next;
    logic        m_cmp_reg, m_dz_reg;
    logic [31:0] quot;

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    q24alu_front #(
        .FRAC_BITS(FRAC_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .in_func  (func_t'(s_tdata[3:0])),
        .in_a     (s_tdata[35:4]),
        .in_b     (s_tdata[67:36]),
        .out_ctrl (st_ctrl[0]),
        .out_res  (st_res[0]),
        .out_nq   (st_nq[0]),
        .out_d    (st_d[0])
    );

    assign st_rem[0] = '0;

    for (genvar i = 0; i < NW; i++) begin : g_cell
        q24alu_div_cell #(
            .NW(NW)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_ctrl  (st_ctrl[i]),
            .in_res   (st_res[i]),
            .in_nq    (st_nq[i]),
            .in_rem   (st_rem[i]),
            .in_d     (st_d[i]),
            .out_ctrl (st_ctrl[i+1]),
            .out_res  (st_res[i+1]),
            .out_nq   (st_nq[i+1]),
            .out_rem  (st_rem[i+1]),
            .out_d    (st_d[i+1])
        );
    end

    // quotient truncated to 32 bits, sign applied after the magnitude divide
    always_comb begin
        quot = st_nq[NW][31:0];
        if (st_ctrl[NW].dz) begin
            m_res_next = '0;
        end else if (st_ctrl[NW].is_div) begin
            m_res_next = st_ctrl[NW].neg ? 32'(32'd0 - quot) : quot;
        end else begin
            m_res_next = st_res[NW];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= st_ctrl[NW].valid;
        end
        if (en) begin
            m_res_reg <= m_res_next;
            m_cmp_reg <= st_ctrl[NW].cmp;
            m_dz_reg  <= st_ctrl[NW].dz;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_dz_reg, m_cmp_reg, m_res_reg};

    // a divide-by-zero item always carries a zero result
    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_dz_reg |-> m_res_reg == 32'd0)
        else $error("divide by zero item with nonzero result");

    // comparison and divide flags come from disjoint opcodes
    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_dz_reg && m_cmp_reg))
        else $error("compare and divide flags both set");

    // a comparison item carries a zero result
    a_cmp_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_cmp_reg |-> m_res_reg == 32'd0)
        else $error("comparison item with nonzero result");

    // an empty output register never blocks the input
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_tready)
        else $error("input stalled with empty output");

endmodule

FILE: tb/sv/q24_alu_checker.sv
// result checker for the q24.8 fixed-point alu: watches both stream channels,
// computes the due result of every accepted item and compares it at the output
// depends on q24alu_pkg for the opcode enum and the fraction width
module q24_alu_checker
    import q24alu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,   // func[3:0], operand_a[35:4], operand_b[67:36], zero[71:68]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // result[31:0], compare_true[32], divide_by_zero[33], zero[39:34]
    output int          mismatches,
    output int          pending
);

    typedef struct packed {
        logic [31:0] result;
        logic        compare_true;
        logic        divide_by_zero;
    } alu_out_t;

    alu_out_t results_due[$];

    function automatic alu_out_t alu_compute(func_t fn, logic signed [31:0] a,
                                             logic signed [31:0] b);
        alu_out_t          r;
        longint            prod;
        longint unsigned   num;
        longint unsigned   den;
        longint unsigned   quo;
        r = '0;
        case (fn)
            FN_ADD: r.result = a + b;
            FN_SUB: r.result = a - b;
            FN_MUL: begin
                // full 64-bit product, then arithmetic shift
                prod = longint'(a) * longint'(b);
                r.result = prod >>> QA_FRAC_BITS;
            end
            FN_DIV: begin
                if (b == 0) begin
                    r.divide_by_zero = 1'b1;
                end else begin
                    // magnitudes, wide dividend, truncation toward zero
                    num = (a < 0) ? longint'(-longint'(a)) : longint'(a);
                    den = (b < 0) ? longint'(-longint'(b)) : longint'(b);
                    num = num << QA_FRAC_BITS;
                    quo = num / den;
                    r.result = ((a < 0) != (b < 0)) ? -quo : quo;
                end
            end
            FN_INC: r.result = a + 32'sd1;
            FN_DEC: r.result = a - 32'sd1;
            FN_GT:  r.compare_true = (a > b);
            FN_LT:  r.compare_true = (a < b);
            FN_GE:  r.compare_true = (a >= b);
            FN_LE:  r.compare_true = (a <= b);
            FN_EQ:  r.compare_true = (a == b);
            FN_NE:  r.compare_true = (a != b);
            FN_MIN: r.result = (a <= b) ? a : b;
            FN_MAX: r.result = (a >= b) ? a : b;
            FN_I2F: r.result = a << QA_FRAC_BITS;
            default: r.result = a >>> QA_FRAC_BITS;
        endcase
        return r;
    endfunction

    initial begin
        mismatches = 0;
        pending = 0;
    end

    always @(posedge aclk) begin
        alu_out_t due;
        alu_out_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                results_due.push_back(alu_compute(func_t'(s_tdata[3:0]),
                                                  s_tdata[35:4], s_tdata[67:36]));
            end
            if (m_tvalid && m_tready) begin
                got.result = m_tdata[31:0];
                got.compare_true = m_tdata[32];
                got.divide_by_zero = m_tdata[33];
                if (results_due.size() == 0) begin
                    $error("result item with nothing due: %h", m_tdata);
                    mismatches <= mismatches + 1;
                end else begin
                    due = results_due.pop_front();
                    if (got.result !== due.result) begin
                        $error("result: expected %h, got %h", due.result, got.result);
                    end
                    if (got.compare_true !== due.compare_true) begin
                        $error("compare_true: expected %b, got %b",
                               due.compare_true, got.compare_true);
                    end
                    if (got.divide_by_zero !== due.divide_by_zero) begin
                        $error("divide_by_zero: expected %b, got %b",
                               due.divide_by_zero, got.divide_by_zero);
                    end
                    if (got !== due) begin
                        mismatches <= mismatches + 1;
                    end
                end
            end
            pending <= results_due.size();
        end
    end

endmodule

FILE: tb/sv/tb_q24_8_fixed_point_alu.sv
// testbench top for the q24.8 fixed-point alu: clock, reset, item stimulus and
// random output back-pressure; depends on q24alu_pkg, the block and q24_alu_checker
module tb_q24_8_fixed_point_alu;
    import q24alu_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 250;
    localparam int DRAIN_WAIT  = 60;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;   // func[3:0], operand_a[35:4], operand_b[67:36], zero[71:68]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // result[31:0], compare_true[32], divide_by_zero[33], zero[39:34]

    int mismatches;
    int pending;
    int cycles = 0;
    bit rx_idle_en = 1'b1;
    bit long_hold_req = 1'b0;

    q24_8_fixed_point_alu DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    q24_alu_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // holds the valid high until the item is taken
    task automatic offer_op(input func_t fn, input logic [31:0] a, input logic [31:0] b);
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, b, a, fn};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic sender_gap(input bit allowed);
        if (allowed && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
    endtask

    function automatic logic [31:0] pick_operand();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom_range(0, 1023) - 512;
            1: begin
                case ($urandom_range(0, 4))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7fff_ffff;
                    2: v = 32'h0000_0000;
                    3: v = 32'hffff_ffff;
                    default: v = 32'h0000_0001;
                endcase
            end
            // whole-ish values within a modest range
            2: v = ($urandom_range(0, 131071) - 65536) << QA_FRAC_BITS;
            3: v = $urandom_range(0, 65535) - 32768;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic random_ops(input int count, input bit gaps);
        logic [31:0] a;
        logic [31:0] b;
        func_t       fn;
        for (int i = 0; i < count; i++) begin
            fn = func_t'($urandom_range(0, 15));
            a = pick_operand();
            b = ($urandom_range(0, 7) == 0) ? a : pick_operand();
            offer_op(fn, a, b);
            sender_gap(gaps);
        end
    endtask

    // receiver: random stalls, plus one long hold when asked
    initial begin
        wait (aresetn);
        m_tready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (long_hold_req) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                m_tready <= 1'b1;
                long_hold_req = 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: wrap edges, every opcode, zero divisor, quotient overflow
        offer_op(FN_ADD, 32'h7fff_ffff, 32'h0000_0001);
        offer_op(FN_SUB, 32'h8000_0000, 32'h0000_0001);
        offer_op(FN_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
        offer_op(FN_MUL, 32'h8000_0000, 32'h8000_0000);
        offer_op(FN_MUL, 32'hffff_ff80, 32'h0000_0180);
        offer_op(FN_DIV, 32'h0000_0100, 32'h0000_0000);
        offer_op(FN_DIV, 32'h8000_0000, 32'h0000_0001);
        offer_op(FN_DIV, 32'hffff_fd00, 32'h0000_0200);
        offer_op(FN_DIV, 32'h7fff_ffff, 32'hffff_ffff);
        offer_op(FN_DIV, 32'h0000_0000, 32'h8000_0000);
        offer_op(FN_INC, 32'h7fff_ffff, 32'hffff_ffff);
        offer_op(FN_DEC, 32'h8000_0000, 32'h0000_0000);
        offer_op(FN_GT,  32'h8000_0000, 32'h7fff_ffff);
        offer_op(FN_LT,  32'h8000_0000, 32'h7fff_ffff);
        offer_op(FN_GE,  32'h0000_0005, 32'h0000_0005);
        offer_op(FN_LE,  32'h7fff_ffff, 32'h8000_0000);
        offer_op(FN_EQ,  32'hffff_ffff, 32'hffff_ffff);
        offer_op(FN_NE,  32'h0000_0000, 32'h0000_0000);
        offer_op(FN_MIN, 32'h8000_0000, 32'h7fff_ffff);
        offer_op(FN_MAX, 32'h8000_0000, 32'h7fff_ffff);
        offer_op(FN_I2F, 32'h7fff_ffff, 32'h0000_0000);
        offer_op(FN_I2F, 32'h8000_0000, 32'h0000_0000);
        offer_op(FN_F2I, 32'hffff_ffff, 32'h0000_0000);
        offer_op(FN_F2I, 32'h7fff_ffff, 32'hffff_ffff);

        random_ops(420, 1'b1);

        // back-pressure: keep offering while the output is held off
        long_hold_req = 1'b1;
        random_ops(110, 1'b0);

        rx_idle_en = 1'b0;
        random_ops(100, 1'b0);
        s_tvalid <= 1'b0;

        do @(posedge aclk); while (pending != 0);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
